### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/hrcm_pkg.sv
// Package for the height rank color map unit: sizes, function codes, states, bands.
// No dependencies; imported by height_rank_color_map_unit.
package hrcm_pkg;

   localparam int DEPTH       = 1024;
   localparam int HEIGHT_BITS = 16;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS    = $clog2(DEPTH + 1);
   // q = 4r and multiples of u up to 4u
   localparam int VAL_BITS    = CNT_BITS + 2;
   // divider dividend 510*num + u < 512*u
   localparam int REM_BITS    = CNT_BITS + 9;
   localparam int DEN_BITS    = CNT_BITS + 1;
   localparam int WORD_BITS   = HEIGHT_BITS + 1;

   typedef enum logic [1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_QUERY  = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QREAD,
      ST_QWAIT,
      ST_SCAN,
      ST_WRITE,
      ST_BAND,
      ST_DIV,
      ST_OUT
   } state_type;

   // jet ramp segments, lowest first
   typedef enum logic [1:0] {
      BAND_BLUE_GREEN,
      BAND_GREEN_CYAN,
      BAND_YELLOW,
      BAND_RED
   } band_type;

endpackage

### rtl/core/height_rank_color_map_unit.sv
// Height rank color map unit: height store in one synchronous RAM, rank scan, jet ramp.
// Depends on hrcm_pkg and assert_macros.svh.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_func, req_height, req_vertex_index
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_red, rsp_green, rsp_blue,
//          |           |                        | rsp_index_error
//
// Append: one RAM read per stored entry, a check of the last read, then one write;
// with an empty store there is nothing to read.
// Query: entry read, RAM scan, band select, 8-step divider, output.
// Clear and unused codes finish in the idle state; bad-index queries go straight to output.
// The scan grows with stored_count. Reset clears only the counts and control.
// A result held by rsp_ready low stalls the next query at output and all later requests.
`include "assert_macros.svh"

module height_rank_color_map_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_func,
   input  logic signed [15:0]                 req_height,
   input  logic [9:0]                         req_vertex_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_red,
   output logic [7:0]                         rsp_green,
   output logic [7:0]                         rsp_blue,
   output logic                               rsp_index_error
);
   import hrcm_pkg::*;

   // height RAM: {height, first mark}
   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_wa;
   logic [WORD_BITS-1:0] mem_wd;
   logic [ADDR_BITS-1:0] mem_ra;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] stored_count_ff, stored_count_in;
   logic [CNT_BITS-1:0] distinct_count_ff, distinct_count_in;
   logic [CNT_BITS-1:0] scan_ptr_ff, scan_ptr_in;
   logic                chk_ff, chk_in;
   logic                seen_ff, seen_in;
   logic [CNT_BITS-1:0] rank_ff, rank_in;
   logic                is_query_ff, is_query_in;
   logic                err_ff, err_in;
   logic signed [HEIGHT_BITS-1:0] key_ff, key_in;
   logic [9:0]          idx_ff, idx_in;
   band_type            band_ff, band_in;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [2:0]          div_cnt_ff, div_cnt_in;
   logic [7:0]          quot_ff, quot_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_red_ff, rsp_red_in;
   logic [7:0]          rsp_green_ff, rsp_green_in;
   logic [7:0]          rsp_blue_ff, rsp_blue_in;
   logic                rsp_err_ff, rsp_err_in;
   logic                rsp_load;

   logic [VAL_BITS-1:0] q_val, u_val, u2_val, u3_val, u4_val, num_val;
   logic [REM_BITS-1:0] num_ext, trial;
   logic signed [HEIGHT_BITS-1:0] rd_height;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red         = rsp_red_ff;
   assign rsp_green       = rsp_green_ff;
   assign rsp_blue        = rsp_blue_ff;
   assign rsp_index_error = rsp_err_ff;

   assign rd_height = $signed(rd_data_ff[WORD_BITS-1:1]);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   // band arithmetic, only meaningful in ST_BAND
   always_comb begin
      q_val   = VAL_BITS'(rank_ff) << 2;
      u_val   = VAL_BITS'(distinct_count_ff);
      u2_val  = u_val << 1;
      u3_val  = u2_val + u_val;
      u4_val  = u_val << 2;
      num_val = '0;
      band_in = band_ff;
      if (q_val <= u_val) begin
         band_in = BAND_BLUE_GREEN;
         num_val = q_val;
      end else if (q_val <= u2_val) begin
         band_in = BAND_GREEN_CYAN;
         num_val = u2_val - q_val;
      end else if (q_val <= u3_val) begin
         band_in = BAND_YELLOW;
         num_val = q_val - u2_val;
      end else begin
         band_in = BAND_RED;
         num_val = u4_val - q_val;
      end
      num_ext = REM_BITS'(num_val);
   end

   assign trial = REM_BITS'(den_ff) << div_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         stored_count_ff   <= '0;
         distinct_count_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         stored_count_ff   <= stored_count_in;
         distinct_count_ff <= distinct_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff  <= scan_ptr_in;
      chk_ff       <= chk_in;
      seen_ff      <= seen_in;
      rank_ff      <= rank_in;
      is_query_ff  <= is_query_in;
      err_ff       <= err_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      band_ff      <= (state_ff == ST_BAND) ? band_in : band_ff;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      div_cnt_ff   <= div_cnt_in;
      quot_ff      <= quot_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_comb begin
      state_in          = state_ff;
      stored_count_in   = stored_count_ff;
      distinct_count_in = distinct_count_ff;
      scan_ptr_in       = scan_ptr_ff;
      chk_in            = chk_ff;
      seen_in           = seen_ff;
      rank_in           = rank_ff;
      is_query_in       = is_query_ff;
      err_in            = err_ff;
      key_in            = key_ff;
      idx_in            = idx_ff;
      rem_in            = rem_ff;
      den_in            = den_ff;
      div_cnt_in        = div_cnt_ff;
      quot_in           = quot_ff;
      mem_we            = 1'b0;
      mem_wa            = stored_count_ff[ADDR_BITS-1:0];
      mem_wd            = {key_ff, ~seen_ff};
      mem_ra            = scan_ptr_ff[ADDR_BITS-1:0];
      rsp_load          = 1'b0;
      rsp_red_in        = rsp_red_ff;
      rsp_green_in      = rsp_green_ff;
      rsp_blue_in       = rsp_blue_ff;
      rsp_err_in        = rsp_err_ff;

      case (state_ff)
         ST_IDLE: begin
            scan_ptr_in = '0;
            chk_in      = 1'b0;
            seen_in     = 1'b0;
            rank_in     = '0;
            key_in      = HEIGHT_BITS'(req_height);
            idx_in      = req_vertex_index;
            if (req_valid) begin
               case (req_func)
                  FUNC_APPEND: begin
                     is_query_in = 1'b0;
                     // drop the item when the store is full
                     if (32'(stored_count_ff) < DEPTH) begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_QUERY: begin
                     is_query_in = 1'b1;
                     if (32'(req_vertex_index) >= 32'(stored_count_ff) ||
                         distinct_count_ff == '0) begin
                        err_in   = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        err_in   = 1'b0;
                        state_in = ST_QREAD;
                     end
                  end
                  FUNC_CLEAR: begin
                     stored_count_in   = '0;
                     distinct_count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_QREAD: begin
            mem_ra   = ADDR_BITS'(idx_ff);
            state_in = ST_QWAIT;
         end
         ST_QWAIT: begin
            key_in   = rd_height;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // issue one read a cycle; check the data in the cycle after
            if (scan_ptr_ff < stored_count_ff) begin
               scan_ptr_in = scan_ptr_ff + 1'b1;
               chk_in      = 1'b1;
            end else begin
               chk_in = 1'b0;
            end
            if (chk_ff) begin
               if (is_query_ff) begin
                  if (rd_data_ff[0] && (rd_height < key_ff)) begin
                     rank_in = rank_ff + 1'b1;
                  end
               end else if (rd_height == key_ff) begin
                  seen_in = 1'b1;
               end
            end
            if (!chk_ff && scan_ptr_ff >= stored_count_ff) begin
               state_in = is_query_ff ? ST_BAND : ST_WRITE;
            end
         end
         ST_WRITE: begin
            mem_we          = 1'b1;
            stored_count_in = stored_count_ff + 1'b1;
            if (!seen_ff) begin
               distinct_count_in = distinct_count_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_BAND: begin
            // dividend 510*num + u, divisor 2u: rounds 255*num/u half up
            rem_in     = (num_ext << 9) - (num_ext << 1) + REM_BITS'(distinct_count_ff);
            den_in     = DEN_BITS'(distinct_count_ff) << 1;
            div_cnt_in = 3'd7;
            quot_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (rem_ff >= trial) begin
               rem_in              = rem_ff - trial;
               quot_in[div_cnt_ff] = 1'b1;
            end
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == 3'd0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load   = 1'b1;
               rsp_err_in = err_ff;
               state_in   = ST_IDLE;
               if (err_ff) begin
                  rsp_red_in   = '0;
                  rsp_green_in = '0;
                  rsp_blue_in  = '0;
               end else begin
                  case (band_ff)
                     BAND_BLUE_GREEN: begin
                        rsp_red_in   = 8'd0;
                        rsp_green_in = quot_ff;
                        rsp_blue_in  = 8'd255;
                     end
                     BAND_GREEN_CYAN: begin
                        rsp_red_in   = 8'd0;
                        rsp_green_in = 8'd255;
                        rsp_blue_in  = quot_ff;
                     end
                     BAND_YELLOW: begin
                        rsp_red_in   = quot_ff;
                        rsp_green_in = 8'd255;
                        rsp_blue_in  = 8'd0;
                     end
                     default: begin
                        rsp_red_in   = 8'd255;
                        rsp_green_in = quot_ff;
                        rsp_blue_in  = 8'd0;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   `ASSERT_NOW(a_distinct_le_stored, clock, reset, 1'b1, distinct_count_ff <= stored_count_ff)
   `ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, 32'(stored_count_ff) <= DEPTH)
   `ASSERT_NOW(a_div_nonzero, clock, reset, state_ff == ST_DIV, den_ff != '0)
   `ASSERT_NEXT(a_full_drop, clock, reset,
      req_valid && req_ready && req_func == FUNC_APPEND && 32'(stored_count_ff) == DEPTH,
      stored_count_ff == $past(stored_count_ff) && state_ff == ST_IDLE)

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for height_rank_color_map_unit: random and directed append, query,
// clear and unused-code items against a behavioral color predictor.
// Depends on hrcm_pkg and the unit's RTL.
module tb_top;
   import hrcm_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS   = 500;
   // room for several full-store queries with idle gaps
   localparam int WATCHDOG_LIMIT = 8000;
   // margin well above the longest item that gives no result
   localparam int DRAIN_CYCLES   = 1100;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [15:0] height;
      logic [9:0]         vertex_index;
   } req_item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       index_error;
   } color_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func = FUNC_APPEND;
   logic signed [15:0] req_height = '0;
   logic [9:0]         req_vertex_index = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_red;
   logic [7:0]         rsp_green;
   logic [7:0]         rsp_blue;
   logic               rsp_index_error;

   req_item_type pending_q[$];
   color_type    color_expected_q[$];
   req_item_type next_item;

   // predictor copy of the height store
   logic signed [HEIGHT_BITS-1:0] store_height [DEPTH];
   bit                            store_first  [DEPTH];
   int                            store_count;
   int                            store_distinct;

   int  planned_count;
   int  mismatch_count;
   int  stall_cycles;
   bit  req_taken;
   bit  rsp_taken;
   int  req_wait;
   int  rsp_wait;
   bit  req_burst;
   bit  rsp_burst;

   height_rank_color_map_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_height       (req_height),
      .req_vertex_index (req_vertex_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_index_error  (rsp_index_error)
   );

   always #10 clock = ~clock;

   // round(255 * num / den), ties up
   function automatic logic [7:0] scale_fraction(input int num, input int den);
      int v;
      v = (510 * num + den) / (2 * den);
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic void predict_color(input logic [1:0] func,
                                         input logic signed [15:0] height,
                                         input logic [9:0] index);
      color_type c;
      bit        seen;
      int        rank;
      int        q;
      int        u;
      if (func == FUNC_APPEND) begin
         if (store_count < DEPTH) begin
            seen = 1'b0;
            for (int i = 0; i < store_count; i++)
               if (store_height[i] == height) seen = 1'b1;
            store_height[store_count] = height;
            store_first[store_count]  = !seen;
            store_count++;
            if (!seen) store_distinct++;
         end
      end else if (func == FUNC_CLEAR) begin
         store_count    = 0;
         store_distinct = 0;
      end else if (func == FUNC_QUERY) begin
         c = '0;
         if (int'(index) >= store_count || store_distinct == 0) begin
            c.index_error = 1'b1;
         end else begin
            rank = 0;
            for (int i = 0; i < store_count; i++)
               if (store_first[i] && store_height[i] < store_height[index]) rank++;
            u = store_distinct;
            q = 4 * rank;
            // a t exactly on a band edge falls into the lower band
            if (q <= u) begin
               c.green = scale_fraction(q, u);
               c.blue  = 8'd255;
            end else if (q <= 2 * u) begin
               c.green = 8'd255;
               c.blue  = scale_fraction(2 * u - q, u);
            end else if (q <= 3 * u) begin
               c.red   = scale_fraction(q - 2 * u, u);
               c.green = 8'd255;
            end else begin
               c.red   = 8'd255;
               c.green = scale_fraction(4 * u - q, u);
            end
         end
         color_expected_q = {color_expected_q, c};
      end
   endfunction

   function automatic void check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
         mismatch_count++;
      end
   endfunction

   function automatic void queue_request(input logic [1:0] func, input logic [15:0] height,
                                         input logic [9:0] index);
      req_item_type it;
      it.func         = func;
      it.height       = height;
      it.vertex_index = index;
      pending_q = {pending_q, it};
      if (func == FUNC_APPEND && planned_count < DEPTH) planned_count++;
      if (func == FUNC_CLEAR) planned_count = 0;
   endfunction

   // coarse values repeat often, which exercises duplicate heights
   function automatic logic [15:0] pick_height(input int mode);
      case (mode)
         0:       return 16'($urandom);
         1:       return {4'($urandom_range(0, 15)), 12'h000};
         default: return 16'($signed($urandom_range(0, 40)) - 20);
      endcase
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_wait  = req_burst ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
         end
         if (req_wait == 0 && pending_q.size() > 0) begin
            next_item = pending_q.pop_front();
            req_valid        <= 1'b1;
            req_func         <= next_item.func;
            req_height       <= next_item.height;
            req_vertex_index <= next_item.vertex_index;
         end else begin
            req_valid <= 1'b0;
            if (req_wait > 0) req_wait--;
         end
      end
   end

   // result-side ready with random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_wait  = rsp_burst ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         end
         if (rsp_wait == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      color_type c;
      if (!reset) begin
         stall_cycles++;
         if (req_valid && req_ready) begin
            predict_color(req_func, req_height, req_vertex_index);
            req_taken    = 1'b1;
            stall_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_taken    = 1'b1;
            stall_cycles = 0;
            if (color_expected_q.size() == 0) begin
               $display("%0t: unexpected item, expected none, got r %0d g %0d b %0d err %0d",
                        $time, rsp_red, rsp_green, rsp_blue, rsp_index_error);
               mismatch_count++;
            end else begin
               c = color_expected_q.pop_front();
               check_field("red", c.red, rsp_red);
               check_field("green", c.green, rsp_green);
               check_field("blue", c.blue, rsp_blue);
               check_field("index_error", c.index_error, rsp_index_error);
            end
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int random_end;
      int n;
      int mode;
      logic [9:0] idx;

      // directed: empty-store query, unused code, extremes, duplicate, band edges
      queue_request(FUNC_QUERY, 16'h0000, 10'd0);
      queue_request(FUNC_UNUSED, 16'hffff, 10'h3ff);
      queue_request(FUNC_APPEND, 16'h8000, 10'h3ff);
      queue_request(FUNC_APPEND, 16'h7fff, 10'h000);
      queue_request(FUNC_APPEND, 16'h0000, 10'h155);
      queue_request(FUNC_APPEND, 16'h8000, 10'h2aa);
      queue_request(FUNC_APPEND, 16'hffff, 10'h000);
      // four distinct heights: ranks 0..3 give t = 0, 1, 2, 3
      for (int i = 0; i < 5; i++) queue_request(FUNC_QUERY, 16'h5a5a, 10'(i));
      queue_request(FUNC_UNUSED, 16'h0000, 10'd0);
      queue_request(FUNC_QUERY, 16'h0000, 10'd5);
      queue_request(FUNC_QUERY, 16'h0000, 10'h3ff);
      queue_request(FUNC_CLEAR, 16'h1234, 10'h2aa);
      queue_request(FUNC_QUERY, 16'h0000, 10'd0);
      queue_request(FUNC_APPEND, 16'h0500, 10'd0);
      queue_request(FUNC_QUERY, 16'h0000, 10'd0);

      // random: mostly append runs followed by queries, some noise
      random_end = pending_q.size() + RANDOM_ITEMS;
      while (pending_q.size() < random_end) begin
         if (planned_count > 200 || $urandom_range(0, 3) != 0)
            queue_request(FUNC_CLEAR, 16'($urandom), 10'($urandom));
         n    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
         mode = $urandom_range(0, 2);
         for (int i = 0; i < n; i++)
            queue_request(FUNC_APPEND, pick_height(mode), 10'($urandom));
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            if (planned_count > 0 && $urandom_range(0, 7) != 0)
               idx = 10'($urandom_range(0, planned_count - 1));
            else
               idx = 10'($urandom_range(planned_count, 1023));
            queue_request(FUNC_QUERY, 16'($urandom), idx);
         end
         if ($urandom_range(0, 4) == 0)
            queue_request(FUNC_UNUSED, 16'($urandom), 10'($urandom));
      end

      queue_request(FUNC_CLEAR, 16'h0000, 10'd0);
      queue_request(FUNC_QUERY, 16'h0000, 10'h3ff);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || req_valid || color_expected_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### height_rank_color_map_unit.f
+incdir+rtl/core
rtl/core/hrcm_pkg.sv
rtl/core/height_rank_color_map_unit.sv
bench/tb_top.sv
